// ----- rtl/core/wpc_pkg.sv -----
// Shared types and constants for the sliding-window peak counter.
// Depends on nothing; every module of the block imports it.
package wpc_pkg;

   localparam int WPC_MAX_WINDOW  = 1024;
   localparam int WPC_MAX_SEQ_LEN = 65536;
   localparam int WPC_QUEUE_DEPTH = 4;

   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 11;
   localparam int PARTS_W  = 10;
   localparam int INDEX_W  = 17;

   localparam int K_MIN   = 3;
   localparam int K_RESET = 3;

   // Per-item control bits handed from front to back
   typedef struct packed {
      logic live;      // sample counts toward the sequence
      logic flag;      // previous position was a strict peak
      logic drop;      // oldest interior flag leaves the window
      logic full;      // a whole window ends at this sample
      logic old_flag;  // flag read back from the ring
      logic last;      // final sample of the sequence
      logic ovf;       // sequence went past its length limit
   } wpc_ctl_type;

endpackage

// ----- rtl/core/wpc_front.sv -----
// Front end: takes samples, detects peaks, keeps the flag ring and window length.
// Depends on wpc_pkg; feeds wpc_queue.
module wpc_front import wpc_pkg::*; #(
   parameter int MAX_WINDOW  = WPC_MAX_WINDOW,
   parameter int MAX_SEQ_LEN = WPC_MAX_SEQ_LEN,
   parameter int QUEUE_DEPTH = WPC_QUEUE_DEPTH,
   localparam int POS_W = $clog2(MAX_SEQ_LEN + 1),
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_window_len,
   input  logic [LVL_W-1:0]    q_level,
   output logic                push,
   output wpc_ctl_type         push_ctl,
   output logic [POS_W-1:0]    push_start
);

   localparam int KW = $clog2(MAX_WINDOW + 1);
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = ((POS_W > KW) ? POS_W : KW) + 1;

   logic [KW-1:0]       k_ff;
   logic [KW-1:0]       k_in;
   logic [SAMPLE_W-1:0] prev_ff, prev2_ff;
   logic [POS_W-1:0]    position_ff;
   logic [AW-1:0]       ring_ptr_ff;
   logic                too_long_ff;
   logic                flag_ram_ff [MAX_WINDOW];
   logic                old_flag_ff;
   logic                s1_valid_ff;
   wpc_ctl_type         s1_ctl_ff;
   logic [POS_W-1:0]    s1_start_ff;

   logic                fire;
   logic                live;
   logic [CW-1:0]       pos_w;
   logic [CW-1:0]       k_w;
   logic                flag;
   logic [KW-1:0]       km2;
   logic [KW-1:0]       ptr_w;
   logic [KW-1:0]       rd_w;
   logic [AW-1:0]       rd_idx;
   wpc_ctl_type         ctl;
   logic [POS_W-1:0]    start;

   // Hold input while the queue could not take what is in flight
   assign req_stall = ({1'b0, q_level} + (LVL_W + 1)'(s1_valid_ff))
                      >= (LVL_W + 1)'(QUEUE_DEPTH);
   assign fire      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // Clamp the window length on write
   always_comb begin
      if (csr_window_len < CFG_W'(K_MIN)) begin
         k_in = KW'(K_MIN);
      end else if (32'(csr_window_len) > 32'(MAX_WINDOW)) begin
         k_in = KW'(MAX_WINDOW);
      end else begin
         k_in = KW'(csr_window_len);
      end
   end

   // Take a new length only between sequences
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= KW'(K_RESET);
      end else if (csr_valid && position_ff == '0) begin
         k_ff <= k_in;
      end
   end

   // Classify the sample against its position and the window
   always_comb begin
      live  = position_ff < POS_W'(MAX_SEQ_LEN);
      pos_w = CW'(position_ff) + CW'(1);
      k_w   = CW'(k_ff);
      flag  = (position_ff >= POS_W'(2)) && (prev_ff > prev2_ff) && (prev_ff > req_sample);
      start = POS_W'(pos_w - k_w + CW'(1));
      ctl.live     = live;
      ctl.flag     = flag;
      ctl.drop     = pos_w > k_w;
      ctl.full     = pos_w >= k_w;
      ctl.old_flag = 1'b0;
      ctl.last     = req_last;
      ctl.ovf      = too_long_ff | ~live;
   end

   // Ring slot of the oldest interior flag, modulo the ring size
   always_comb begin
      km2   = k_ff - KW'(2);
      ptr_w = KW'(ring_ptr_ff);
      if (ptr_w >= km2) begin
         rd_w = ptr_w - km2;
      end else begin
         rd_w = ptr_w + (KW'(MAX_WINDOW) - km2);
      end
      rd_idx = AW'(rd_w);
   end

   // Flag ring: write the new flag, read the one leaving the window
   always_ff @(posedge clock) begin
      if (fire && live && position_ff != '0) begin
         flag_ram_ff[ring_ptr_ff] <= flag;
      end
      if (fire && live) begin
         old_flag_ff <= flag_ram_ff[rd_idx];
      end
   end

   // Advance sequence state, clear it after the last beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         prev2_ff    <= '0;
         position_ff <= '0;
         ring_ptr_ff <= '0;
         too_long_ff <= 1'b0;
      end else if (fire) begin
         if (req_last) begin
            prev_ff     <= '0;
            prev2_ff    <= '0;
            position_ff <= '0;
            ring_ptr_ff <= '0;
            too_long_ff <= 1'b0;
         end else if (live) begin
            prev2_ff    <= prev_ff;
            prev_ff     <= req_sample;
            position_ff <= POS_W'(pos_w);
            ring_ptr_ff <= (ring_ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : ring_ptr_ff + AW'(1);
         end else begin
            too_long_ff <= 1'b1;
         end
      end
   end

   // Stage the item until the ring read returns
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_ctl_ff   <= ctl;
         s1_start_ff <= start;
      end
   end

   // Push the staged item with its old flag attached
   always_comb begin
      push_ctl          = s1_ctl_ff;
      push_ctl.old_flag = old_flag_ff;
   end
   assign push       = s1_valid_ff;
   assign push_start = s1_start_ff;

   // Position never passes the limit
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_W'(MAX_SEQ_LEN))
      else $error("position beyond limit");

   // Last beat leaves a clean sequence state
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && req_last) |=> (position_ff == '0 && ring_ptr_ff == '0 && !too_long_ff))
      else $error("sequence state not cleared");

endmodule

// ----- rtl/core/wpc_queue.sv -----
// Small FIFO decoupling peak detection from window scoring.
// Depends on wpc_pkg for the default depth.
module wpc_queue import wpc_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = WPC_QUEUE_DEPTH,
   localparam int LVL_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic [LVL_W-1:0] level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [LVL_W-1:0] level_ff;

   assign head_data = slot_ff[rd_ptr_ff];
   assign level     = level_ff;

   // Store incoming beats
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Move pointers and the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

   // Never write into a full queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (level_ff < LVL_W'(DEPTH)))
      else $error("queue overrun");

   // Never read an empty queue
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("queue underrun");

endmodule

// ----- rtl/core/wpc_back.sv -----
// Back end: keeps the window peak count and the best window, drives results.
// Depends on wpc_pkg; drains wpc_queue.
module wpc_back import wpc_pkg::*; #(
   parameter int MAX_WINDOW  = WPC_MAX_WINDOW,
   parameter int MAX_SEQ_LEN = WPC_MAX_SEQ_LEN,
   localparam int POS_W = $clog2(MAX_SEQ_LEN + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  wpc_ctl_type        head_ctl,
   input  logic [POS_W-1:0]   head_start,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PARTS_W-1:0] rsp_max_parts,
   output logic [INDEX_W-1:0] rsp_left_index,
   output logic               rsp_found,
   output logic               rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_WINDOW);

   logic [CNT_W-1:0]   window_peaks_ff;
   logic [CNT_W-1:0]   best_peaks_ff;
   logic [POS_W-1:0]   best_start_ff;
   logic               have_best_ff;
   logic               rsp_valid_ff;
   logic [PARTS_W-1:0] max_parts_ff;
   logic [INDEX_W-1:0] left_index_ff;
   logic               found_ff;
   logic               overflow_ff;

   logic [CNT_W-1:0]   wp_new;
   logic               better;
   logic [CNT_W-1:0]   best_peaks_nx;
   logic [POS_W-1:0]   best_start_nx;
   logic               have_best_nx;
   logic [CNT_W:0]     parts_sum;

   // Drain the queue unless a result is still waiting
   assign pop = head_valid & ~(rsp_valid_ff & rsp_stall);

   // Update the window count and pick the best window
   always_comb begin
      wp_new = window_peaks_ff + CNT_W'(head_ctl.flag)
               - CNT_W'(head_ctl.drop & head_ctl.old_flag);
      better = head_ctl.live && head_ctl.full && (!have_best_ff || wp_new > best_peaks_ff);
      best_peaks_nx = better ? wp_new : best_peaks_ff;
      best_start_nx = better ? head_start : best_start_ff;
      have_best_nx  = have_best_ff | better;
      parts_sum     = {1'b0, best_peaks_nx} + (CNT_W + 1)'(1);
   end

   // Window and best-window state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_peaks_ff <= '0;
         best_peaks_ff   <= '0;
         best_start_ff   <= '0;
         have_best_ff    <= 1'b0;
      end else if (pop) begin
         if (head_ctl.last) begin
            window_peaks_ff <= '0;
            best_peaks_ff   <= '0;
            best_start_ff   <= '0;
            have_best_ff    <= 1'b0;
         end else begin
            if (head_ctl.live) begin
               window_peaks_ff <= wp_new;
            end
            best_peaks_ff <= best_peaks_nx;
            best_start_ff <= best_start_nx;
            have_best_ff  <= have_best_nx;
         end
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head_ctl.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop && head_ctl.last) begin
         max_parts_ff  <= have_best_nx ? PARTS_W'(parts_sum) : '0;
         left_index_ff <= have_best_nx ? INDEX_W'(best_start_nx) : '0;
         found_ff      <= have_best_nx;
         overflow_ff   <= head_ctl.ovf;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_parts  = max_parts_ff;
   assign rsp_left_index = left_index_ff;
   assign rsp_found      = found_ff;
   assign rsp_overflow   = overflow_ff;

   // A result is never overwritten while waiting
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("result overwritten");

   // Missing window reports zero count and index
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (max_parts_ff == '0 && left_index_ff == '0))
      else $error("empty result carries data");

   // End of sequence clears the scoring state
   a_seq_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && head_ctl.last) |=> (!have_best_ff && window_peaks_ff == '0))
      else $error("scoring state not cleared");

endmodule

// ----- rtl/core/window_peak_count_max.sv -----
// Sliding-window peak counter, top level: front, queue and back.
// Throughput: one sample per cycle sustained while rsp_stall stays low.
// The result of a sequence passes the flag ring read stage, then the queue slot,
// and the result register loads as that last item pops.
// Reset: synchronous; clears control state at once, no clearing pass.
// Depends on wpc_pkg, wpc_front, wpc_queue and wpc_back.
module window_peak_count_max import wpc_pkg::*; #(
   parameter int MAX_WINDOW  = WPC_MAX_WINDOW,
   parameter int MAX_SEQ_LEN = WPC_MAX_SEQ_LEN,
   parameter int QUEUE_DEPTH = WPC_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PARTS_W-1:0]  rsp_max_parts,
   output logic [INDEX_W-1:0]  rsp_left_index,
   output logic                rsp_found,
   output logic                rsp_overflow,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_window_len
);

   localparam int POS_W = $clog2(MAX_SEQ_LEN + 1);
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CTL_W = $bits(wpc_ctl_type);
   localparam int Q_W   = CTL_W + POS_W;

   logic               push;
   wpc_ctl_type        push_ctl;
   logic [POS_W-1:0]   push_start;
   logic [LVL_W-1:0]   q_level;
   logic [Q_W-1:0]     head_data;
   wpc_ctl_type        head_ctl;
   logic [POS_W-1:0]   head_start;
   logic               pop;

   wpc_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_SEQ_LEN (MAX_SEQ_LEN),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len),
      .q_level        (q_level),
      .push           (push),
      .push_ctl       (push_ctl),
      .push_start     (push_start)
   );

   wpc_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_start}),
      .pop       (pop),
      .head_data (head_data),
      .level     (q_level)
   );

   // Split the queue head back into control and start index
   assign head_ctl   = wpc_ctl_type'(head_data[Q_W-1:POS_W]);
   assign head_start = head_data[POS_W-1:0];

   wpc_back #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_level != '0),
      .head_ctl       (head_ctl),
      .head_start     (head_start),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_max_parts  (rsp_max_parts),
      .rsp_left_index (rsp_left_index),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow)
   );

endmodule
